/* src/assert_macros.svh */
// Assertion macros shared by the divider's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/sdiv128_pkg.sv */
`default_nettype none

package sdiv128_pkg;

   localparam int WORD_W     = 64;
   localparam int FULL_W     = 2 * WORD_W;
   localparam int REM_HIGH_W = WORD_W - 1;
   localparam int DIV_STEPS  = FULL_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [FULL_W-1:0] full_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // Two's complement negation of a 128-bit value.
   function automatic full_type negate(input full_type v);
      return ~v + full_type'(1);
   endfunction

endpackage

`default_nettype wire

/* src/sdiv128_req_if.sv */
`default_nettype none

interface sdiv128_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [sdiv128_pkg::WORD_W-1:0]    dividend_high;
   logic        [sdiv128_pkg::WORD_W-1:0]    dividend_low;
   logic signed [sdiv128_pkg::WORD_W-1:0]    divisor_high;
   logic        [sdiv128_pkg::WORD_W-1:0]    divisor_low;

   modport source (output valid, dividend_high, dividend_low, divisor_high, divisor_low,
                   input ready);
   modport sink (input valid, dividend_high, dividend_low, divisor_high, divisor_low,
                 output ready);
endinterface

`default_nettype wire

/* src/sdiv128_rsp_if.sv */
`default_nettype none

interface sdiv128_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [sdiv128_pkg::WORD_W-1:0]     quotient_high;
   logic        [sdiv128_pkg::WORD_W-1:0]     quotient_low;
   logic        [sdiv128_pkg::REM_HIGH_W-1:0] remainder_high;
   logic        [sdiv128_pkg::WORD_W-1:0]     remainder_low;
   logic                                      divide_by_zero;

   modport source (output valid, quotient_high, quotient_low, remainder_high,
                   remainder_low, divide_by_zero, input ready);
   modport sink (input valid, quotient_high, quotient_low, remainder_high,
                 remainder_low, divide_by_zero, output ready);
endinterface

`default_nettype wire

/* src/sdiv128_datapath.sv */
`default_nettype none

module sdiv128_datapath (
   input  wire                                    clock,
   input  wire                                    reset,
   input  sdiv128_pkg::cmd_type                   cmd,
   input  wire  signed [sdiv128_pkg::WORD_W-1:0]  dividend_high,
   input  wire         [sdiv128_pkg::WORD_W-1:0]  dividend_low,
   input  wire  signed [sdiv128_pkg::WORD_W-1:0]  divisor_high,
   input  wire         [sdiv128_pkg::WORD_W-1:0]  divisor_low,
   output logic signed [sdiv128_pkg::WORD_W-1:0]  quotient_high,
   output logic        [sdiv128_pkg::WORD_W-1:0]  quotient_low,
   output logic [sdiv128_pkg::REM_HIGH_W-1:0]     remainder_high,
   output logic        [sdiv128_pkg::WORD_W-1:0]  remainder_low,
   output logic                                   divide_by_zero
);
   import sdiv128_pkg::*;

   full_type          a_raw;
   full_type          b_raw;
   full_type          a_mag;
   full_type          b_mag;
   full_type          rem_shift;
   logic [FULL_W:0]   diff;
   logic              fits;
   full_type          quo_signed;

   // The quotient register starts out holding the dividend magnitude; each step
   // shifts one dividend bit out at the top and one quotient bit in at the bottom.
   full_type          quo_ff, quo_in;
   full_type          rem_ff, rem_in;
   full_type          div_ff, div_in;
   logic              flip_ff, flip_in;
   logic              zero_ff, zero_in;

   word_type          q_high_ff, q_low_ff, r_low_ff;
   logic [REM_HIGH_W-1:0] r_high_ff;
   logic              dbz_ff;

   assign a_raw = {dividend_high, dividend_low};
   assign b_raw = {divisor_high, divisor_low};
   assign a_mag = a_raw[FULL_W-1] ? negate(a_raw) : a_raw;
   assign b_mag = b_raw[FULL_W-1] ? negate(b_raw) : b_raw;

   assign rem_shift = {rem_ff[FULL_W-2:0], quo_ff[FULL_W-1]};
   assign diff      = {1'b0, rem_shift} - {1'b0, div_ff};
   assign fits      = ~diff[FULL_W];
   assign quo_signed = flip_ff ? negate(quo_ff) : quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      flip_in = flip_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         quo_in  = a_mag;
         rem_in  = '0;
         div_in  = b_mag;
         flip_in = a_raw[FULL_W-1] ^ b_raw[FULL_W-1];
         zero_in = (b_raw == '0);
      end else if (cmd.step) begin
         quo_in = {quo_ff[FULL_W-2:0], fits};
         rem_in = fits ? diff[FULL_W-1:0] : rem_shift;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      flip_ff <= flip_in;
      zero_ff <= zero_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (zero_ff) begin
            q_high_ff <= '0;
            q_low_ff  <= '0;
            r_high_ff <= '0;
            r_low_ff  <= '0;
            dbz_ff    <= 1'b1;
         end else begin
            q_high_ff <= quo_signed[FULL_W-1:WORD_W];
            q_low_ff  <= quo_signed[WORD_W-1:0];
            r_high_ff <= rem_ff[FULL_W-2:WORD_W];
            r_low_ff  <= rem_ff[WORD_W-1:0];
            dbz_ff    <= 1'b0;
         end
      end
   end

   assign quotient_high  = q_high_ff;
   assign quotient_low   = q_low_ff;
   assign remainder_high = r_high_ff;
   assign remainder_low  = r_low_ff;
   assign divide_by_zero = dbz_ff;

`include "assert_macros.svh"

   // The partial remainder stays below a divisor of at most 2^127.
   `ASSERT_NEXT(a_rem_top_clear, clock, reset, cmd.step && !zero_ff, !rem_ff[FULL_W-1])
   `ASSERT_IMPLIES(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(cmd))

endmodule

`default_nettype wire

/* src/sdiv128_ctrl.sv */
`default_nettype none

module sdiv128_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire                   out_ready,
   output sdiv128_pkg::cmd_type  cmd
);
   import sdiv128_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      in_ready = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset is held.
            in_ready = !reset;
            if (in_valid && !reset) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            count_in = count_ff + STEP_W'(1);
            if (count_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // Hold the finished request until the output register is free.
            if (!out_valid_ff || out_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_accept_starts, clock, reset, in_valid && in_ready,
                state_ff == ST_DIV && count_ff == '0)
   `ASSERT_IMPLIES(a_emit_free, clock, reset, cmd.emit,
                   state_ff == ST_FIX && (!out_valid_ff || out_ready))
   `ASSERT_IMPLIES(a_valid_from_fix, clock, reset, $rose(out_valid_ff),
                   $past(state_ff) == ST_FIX)

endmodule

`default_nettype wire

/* src/signed_int128_divide_remainder.sv */
// Channel   Dir  Handshake          Contents
// req       in   req.valid/ready    signed 128-bit dividend and divisor, high/low words
// rsp       out  rsp.valid/ready    signed quotient, magnitude remainder, zero flag
//
// A request goes from acceptance to its result in the output register as follows:
// the accept cycle loads the operand magnitudes, then 128 steps each produce one
// quotient bit through the single 128-bit subtractor, then ST_FIX negates the quotient.
// One request is in flight at a time; a new one is accepted while the last result waits.
// A result that cannot leave holds the divider in its last cycle until rsp.ready.
// Reset is synchronous and clears the sequencer and the output valid.
`default_nettype none

module signed_int128_divide_remainder (
   input wire             clock,
   input wire             reset,
   sdiv128_req_if.sink    req,
   sdiv128_rsp_if.source  rsp
);
   import sdiv128_pkg::*;

   cmd_type cmd;

   sdiv128_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd)
   );

   sdiv128_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dividend_high  (req.dividend_high),
      .dividend_low   (req.dividend_low),
      .divisor_high   (req.divisor_high),
      .divisor_low    (req.divisor_low),
      .quotient_high  (rsp.quotient_high),
      .quotient_low   (rsp.quotient_low),
      .remainder_high (rsp.remainder_high),
      .remainder_low  (rsp.remainder_low),
      .divide_by_zero (rsp.divide_by_zero)
   );

endmodule

`default_nettype wire
